// ===== rtl/core/rc_dbus_pkg.sv =====
// Shared types, constants and codes for the remote-control frame decoder.
// Used by every module of the block; depends on nothing.
package rc_dbus_pkg;

  // frame geometry and byte counter
  localparam int FRAME_BYTES = 18;
  localparam int COUNT_MAX   = 36;
  localparam int CNT_W       = 6;

  // channel field constants
  localparam int CH_W               = 11;
  localparam logic [15:0] CH_OFFSET = 16'd1024;
  localparam logic [3:0]  SW_SAFE   = 4'hA;
  localparam int LIMIT_W            = 11;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd660;

  // word kinds carried on the input tuser bit
  localparam logic MODE_DATA = 1'b0;
  localparam logic MODE_IDLE = 1'b1;

  typedef logic [7:0] byte_t;
  typedef byte_t [FRAME_BYTES-1:0] frame_t;

  // one decoded result word
  typedef struct packed {
    logic [CH_W-1:0] ch0;
    logic [CH_W-1:0] ch1;
    logic [CH_W-1:0] ch2;
    logic [CH_W-1:0] ch3;
    logic [15:0]     ch4;
    logic [3:0]      switches;
    logic [15:0]     mouse_x;
    logic [15:0]     mouse_y;
    logic [15:0]     mouse_z;
    logic [15:0]     mouse_buttons;
    logic [15:0]     keys;
    logic            frame_error;
  } result_t;

endpackage

// ===== rtl/core/rc_dbus_cell.sv =====
// One byte cell of the frame shift chain: loads its neighbour's byte on shift.
// Depends on rc_dbus_pkg.
module rc_dbus_cell (
  input  logic               clk,
  input  logic               shift_en,
  input  rc_dbus_pkg::byte_t din,
  output rc_dbus_pkg::byte_t dout
);

  rc_dbus_pkg::byte_t data;

  // hold, or take the byte from the previous cell
  always_ff @(posedge clk) begin
    if (shift_en) begin
      data <= din;
    end
  end

  assign dout = data;

endmodule

// ===== rtl/core/rc_dbus_chain.sv =====
// Row of byte cells holding the first bytes of the current frame.
// Depends on rc_dbus_pkg and rc_dbus_cell; presents the bytes in frame order.
module rc_dbus_chain (
  input  logic                clk,
  input  logic                shift_en,
  input  rc_dbus_pkg::byte_t  din,
  output rc_dbus_pkg::frame_t frame
);

  rc_dbus_pkg::frame_t cell_q;

  // new bytes enter cell 0 and travel towards the far end
  for (genvar i = 0; i < rc_dbus_pkg::FRAME_BYTES; i++) begin : g_cell
    if (i == 0) begin : g_head
      rc_dbus_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .din      (din),
        .dout     (cell_q[i])
      );
    end else begin : g_body
      rc_dbus_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .din      (cell_q[i-1]),
        .dout     (cell_q[i])
      );
    end
    // after a full frame the oldest byte sits in the last cell
    assign frame[i] = cell_q[rc_dbus_pkg::FRAME_BYTES-1-i];
  end

endmodule

// ===== rtl/core/rc_dbus_unpack.sv =====
// Unpacks a complete frame into result fields and applies the safety check.
// Depends on rc_dbus_pkg; purely combinational.
module rc_dbus_unpack (
  input  rc_dbus_pkg::frame_t                      frame,
  input  logic [rc_dbus_pkg::LIMIT_W-1:0]          channel_limit,
  output rc_dbus_pkg::result_t                     result
);

  logic [rc_dbus_pkg::CH_W-1:0] raw [4];
  logic [rc_dbus_pkg::CH_W-1:0] ch  [4];
  logic [11:0]                  mag [4];
  logic [3:0]                   over;
  logic [3:0]                   sw;
  logic [15:0]                  ch4;
  logic                         err;

  // slice the four packed stick channels
  assign raw[0] = {frame[1][2:0], frame[0]};
  assign raw[1] = {frame[2][5:0], frame[1][7:3]};
  assign raw[2] = {frame[4][0], frame[3], frame[2][7:6]};
  assign raw[3] = {frame[5][3:0], frame[4][7:1]};

  // subtract the centre offset and compare the magnitude with the limit
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ch[i]  = raw[i] ^ 11'h400;
      mag[i] = ch[i][10] ? (12'd0 - {ch[i][10], ch[i]}) : {1'b0, ch[i]};
      over[i] = mag[i] > {1'b0, channel_limit};
    end
  end

  assign sw  = frame[5][7:4];
  assign ch4 = {frame[17], frame[16]} - rc_dbus_pkg::CH_OFFSET;
  assign err = (|over) || (sw[1:0] == 2'b00) || (sw[3:2] == 2'b00);

  // force safe values on a failed check
  always_comb begin
    if (err) begin
      result             = '0;
      result.switches    = rc_dbus_pkg::SW_SAFE;
      result.frame_error = 1'b1;
    end else begin
      result.ch0           = ch[0];
      result.ch1           = ch[1];
      result.ch2           = ch[2];
      result.ch3           = ch[3];
      result.ch4           = ch4;
      result.switches      = sw;
      result.mouse_x       = {frame[7], frame[6]};
      result.mouse_y       = {frame[9], frame[8]};
      result.mouse_z       = {frame[11], frame[10]};
      result.mouse_buttons = {frame[13], frame[12]};
      result.keys          = {frame[15], frame[14]};
      result.frame_error   = 1'b0;
    end
  end

endmodule

// ===== rtl/core/rc_dbus_frame_decoder_top.sv =====
// Top level of the remote-control frame decoder: byte counter, cell chain,
// unpacker and a two-entry output stage. Depends on rc_dbus_pkg and submodules.
//
// Usage:
//   Slave stream: each word is one received UART byte (tuser = 0, byte in
//   tdata[7:0]) or an idle-line event (tuser = 1) closing the frame.
//   Master stream: one decoded word per idle event that follows exactly
//   18 bytes; idle events after any other count give nothing.
//   Config channel: cfg_data[10:0] sets the stick magnitude limit; always
//   ready, to be written only while the block is idle.
//   Output: a result is registered in the output register, or in the skid
//   register while the output waits. Throughput: one slave word per cycle
//   while tready is high; data bytes and idle words may run back to back.
//   Stall: results collect in an output register and a skid register; the
//   slave side drops tready only while both hold a word.
//   Reset (rst, synchronous): clears the byte count, empties the output stage
//   and sets the limit to 660. Frame bytes are not cleared; a full frame is
//   always shifted in before one is decoded.
module rc_dbus_frame_decoder_top (
  input  logic         clk,
  input  logic         rst,
  // slave stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] data_byte
  input  logic         s_tuser,   // [0] mode
  // master stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // [10:0] ch0, [21:11] ch1, [32:22] ch2, [43:33] ch3, [59:44] ch4,
  // [63:60] switches, [79:64] mouse_x, [95:80] mouse_y, [111:96] mouse_z,
  // [127:112] mouse_buttons, [143:128] keys
  output logic [143:0] m_tdata,
  output logic         m_tuser,   // [0] frame_error
  // configuration write
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [10:0]  cfg_data   // [10:0] channel_limit
);

  logic [rc_dbus_pkg::CNT_W-1:0]   byte_count;
  logic [rc_dbus_pkg::LIMIT_W-1:0] channel_limit;
  rc_dbus_pkg::frame_t             frame;
  rc_dbus_pkg::result_t            result;
  rc_dbus_pkg::result_t            out_word;
  rc_dbus_pkg::result_t            skid_word;
  logic                            skid_valid;
  logic                            in_fire;
  logic                            data_fire;
  logic                            frame_done;
  logic                            out_free;

  assign in_fire    = s_tvalid && s_tready;
  assign data_fire  = in_fire && (s_tuser == rc_dbus_pkg::MODE_DATA);
  assign frame_done = in_fire && (s_tuser == rc_dbus_pkg::MODE_IDLE) &&
                      (byte_count == rc_dbus_pkg::CNT_W'(rc_dbus_pkg::FRAME_BYTES));
  assign out_free   = !m_tvalid || m_tready;
  assign s_tready   = !skid_valid;
  assign cfg_ready  = 1'b1;

  // shift a byte into the chain only while the frame is still short
  rc_dbus_chain u_chain (
    .clk      (clk),
    .shift_en (data_fire &&
               (byte_count < rc_dbus_pkg::CNT_W'(rc_dbus_pkg::FRAME_BYTES))),
    .din      (s_tdata),
    .frame    (frame)
  );

  rc_dbus_unpack u_unpack (
    .frame         (frame),
    .channel_limit (channel_limit),
    .result        (result)
  );

  // count bytes, saturating; clear on every idle word
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else if (in_fire) begin
      if (s_tuser == rc_dbus_pkg::MODE_IDLE) begin
        byte_count <= '0;
      end else if (byte_count < rc_dbus_pkg::CNT_W'(rc_dbus_pkg::COUNT_MAX)) begin
        byte_count <= byte_count + 1'b1;
      end
    end
  end

  // limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_limit <= rc_dbus_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      channel_limit <= cfg_data;
    end
  end

  // output register with skid: advance the skid word when the output drains
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (m_tready) begin
          skid_valid <= 1'b0;
        end
      end else if (frame_done && !out_free) begin
        skid_valid <= 1'b1;
      end
      if (out_free) begin
        m_tvalid <= skid_valid || frame_done;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_word <= skid_valid ? skid_word : result;
    end
    if (!skid_valid && frame_done && !out_free) begin
      skid_word <= result;
    end
  end

  assign m_tdata = {out_word.keys, out_word.mouse_buttons, out_word.mouse_z,
                    out_word.mouse_y, out_word.mouse_x, out_word.switches,
                    out_word.ch4, out_word.ch3, out_word.ch2, out_word.ch1,
                    out_word.ch0};
  assign m_tuser = out_word.frame_error;

  // skid register only fills behind a waiting output word
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid word held with empty output register");

  // byte count never passes its saturation point
  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    byte_count <= rc_dbus_pkg::CNT_W'(rc_dbus_pkg::COUNT_MAX))
    else $error("byte count beyond saturation");

  // an idle word always restarts the frame
  a_idle_clears: assert property (@(posedge clk) disable iff (rst)
    (in_fire && s_tuser == rc_dbus_pkg::MODE_IDLE) |=> byte_count == '0)
    else $error("byte count not cleared by idle word");

  // an error word carries the safe switch positions
  a_error_safe: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[63:60] == rc_dbus_pkg::SW_SAFE))
    else $error("error word without safe switches");

endmodule

// ===== sim/testbench.sv =====
// Self-checking bench for rc_dbus_frame_decoder_top: drives byte and idle-line
// words, predicts each decoded frame in a scoreboard class and checks results.
// Depends on rc_dbus_pkg and the decoder RTL only.
`timescale 1ns / 100ps

// Frame predictor and store of decoded words still due
class frame_decode_model;
  int                 count;
  rc_dbus_pkg::byte_t frame[rc_dbus_pkg::FRAME_BYTES];
  logic [10:0]        limit;
  logic [144:0]       frames_due[$];   // {frame_error, tdata}
  int                 faults;
  int                 field_lo[12] = '{0, 11, 22, 33, 44, 60, 64, 80, 96, 112, 128, 144};
  int                 field_w[12]  = '{11, 11, 11, 11, 16, 4, 16, 16, 16, 16, 16, 1};
  string              field_name[12] = '{"ch0", "ch1", "ch2", "ch3", "ch4", "switches",
                                         "mouse_x", "mouse_y", "mouse_z", "mouse_buttons",
                                         "keys", "frame_error"};

  function new();
    count  = 0;
    limit  = rc_dbus_pkg::LIMIT_RESET;
    faults = 0;
  endfunction

  function void flag(string msg);
    if (faults < 10) $display("mismatch at %0t: %s", $time, msg);
    faults++;
  endfunction

  function int due_count();
    return frames_due.size();
  endfunction

  // Note one accepted input word and queue the decoded frame it closes, if any
  function void take_word(logic mode, rc_dbus_pkg::byte_t b);
    logic [47:0]  sticks;
    logic [10:0]  raw;
    logic [15:0]  wide;
    logic [3:0]   sw;
    logic [143:0] d;
    int           mag;
    int           i;
    bit           bad;
    if (mode == rc_dbus_pkg::MODE_DATA) begin
      if (count < rc_dbus_pkg::FRAME_BYTES) frame[count] = b;
      if (count < rc_dbus_pkg::COUNT_MAX) count++;
      return;
    end
    if (count != rc_dbus_pkg::FRAME_BYTES) begin
      count = 0;
      return;
    end
    count = 0;
    // bytes 0 to 5 hold four 11-bit sticks then two 2-bit switches, LSB first
    for (i = 0; i < 6; i++) sticks[8*i +: 8] = frame[i];
    bad = 1'b0;
    d   = '0;
    for (i = 0; i < 4; i++) begin
      raw  = sticks[11*i +: 11];
      mag  = int'(raw) - 1024;
      if (mag < 0) mag = -mag;
      if (mag > int'(limit)) bad = 1'b1;
      wide = {5'b0, raw} - rc_dbus_pkg::CH_OFFSET;
      d[11*i +: 11] = wide[10:0];
    end
    sw = sticks[47:44];
    if (sw[1:0] == 2'b00 || sw[3:2] == 2'b00) bad = 1'b1;
    d[59:44]   = {frame[17], frame[16]} - rc_dbus_pkg::CH_OFFSET;
    d[63:60]   = sw;
    d[79:64]   = {frame[7], frame[6]};
    d[95:80]   = {frame[9], frame[8]};
    d[111:96]  = {frame[11], frame[10]};
    d[127:112] = {frame[13], frame[12]};
    d[143:128] = {frame[15], frame[14]};
    // a failed check forces the safe word
    if (bad) begin
      d = '0;
      d[63:60] = rc_dbus_pkg::SW_SAFE;
    end
    frames_due.push_back({bad, d});
  endfunction

  // Compare one decoded word with the oldest frame due
  function void check_frame(logic [143:0] tdata, logic tuser);
    logic [144:0] got, want, wmask;
    int           i;
    got = {tuser, tdata};
    if (frames_due.size() == 0) begin
      flag($sformatf("decoded word with none due, tdata %h tuser %b", tdata, tuser));
      return;
    end
    want = frames_due.pop_front();
    for (i = 0; i < 12; i++) begin
      wmask = (145'd1 << field_w[i]) - 145'd1;
      if (((got >> field_lo[i]) & wmask) != ((want >> field_lo[i]) & wmask))
        flag($sformatf("%s expected %0h got %0h", field_name[i],
                       (want >> field_lo[i]) & wmask, (got >> field_lo[i]) & wmask));
    end
  endfunction
endclass

module testbench;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_WORDS  = 385;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = '0;
  logic         s_tuser = rc_dbus_pkg::MODE_DATA;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [143:0] m_tdata;
  logic         m_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [10:0]  cfg_data = '0;

  frame_decode_model  model = new();
  rc_dbus_pkg::byte_t frame_buf[rc_dbus_pkg::FRAME_BYTES];
  int                 gap_pct   = 0;
  int                 stall_pct = 0;
  bit                 hold_rx   = 1'b0;
  int                 cycles    = 0;
  int                 counted;

  rc_dbus_frame_decoder_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Receiver: stall at random, or hold off entirely during the pressure stretch
  always @(negedge clk) begin
    m_tready <= !hold_rx && ($urandom_range(99) >= stall_pct);
  end

  // Check each decoded word taken on the master side
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) model.check_frame(m_tdata, m_tuser);
  end

  // Offer one word, with random gaps beforehand; enters and leaves at a falling edge
  task automatic send_word(logic mode, rc_dbus_pkg::byte_t b);
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    model.take_word(mode, b);
    @(negedge clk);
  endtask

  task automatic write_limit(logic [10:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model.limit = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Hold until every decoded word has arrived, then let the pipeline settle
  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    while (model.due_count() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Stick value near or inside the limit, mostly legal, sometimes just over
  function automatic logic [10:0] pick_channel(int lim);
    int          lo, hi, v;
    logic [31:0] t;
    lo = -lim;
    hi = (lim > 1023) ? 1023 : lim;
    case ($urandom_range(9))
      0: v = hi;
      1: v = lo;
      2: v = (hi < 1023) ? hi + 1 : hi;
      3: v = (lo > -1024) ? lo - 1 : lo;
      4: v = int'($urandom_range(2047)) - 1024;
      default: v = lo + int'($urandom_range(hi - lo));
    endcase
    t = v + 1024;
    return t[10:0];
  endfunction

  function automatic logic [1:0] pick_switch();
    if ($urandom_range(9) == 0) return 2'b00;
    return 2'($urandom_range(3, 1));
  endfunction

  // Fill frame_buf: mostly plausible sticks and switches, sometimes raw noise
  function automatic void fill_frame(int lim);
    logic [47:0] sticks;
    int          i;
    for (i = 0; i < rc_dbus_pkg::FRAME_BYTES; i++) begin
      case ($urandom_range(19))
        0:       frame_buf[i] = 8'h00;
        1:       frame_buf[i] = 8'hff;
        default: frame_buf[i] = 8'($urandom_range(255));
      endcase
    end
    if ($urandom_range(3) != 0) begin
      sticks = {pick_switch(), pick_switch(), pick_channel(lim), pick_channel(lim),
                pick_channel(lim), pick_channel(lim)};
      for (i = 0; i < 6; i++) frame_buf[i] = sticks[8*i +: 8];
    end
  endfunction

  task automatic send_frame();
    int i;
    fill_frame(int'(model.limit));
    for (i = 0; i < rc_dbus_pkg::FRAME_BYTES; i++)
      send_word(rc_dbus_pkg::MODE_DATA, frame_buf[i]);
    send_word(rc_dbus_pkg::MODE_IDLE, 8'($urandom_range(255)));
  endtask

  // Random traffic: mostly whole frames, some wrong lengths and stray words
  task automatic run_phase(logic [10:0] lim, int snd, int rcv, bit pressure);
    int r, n, i;
    write_limit(lim);
    gap_pct   = snd;
    stall_pct = rcv;
    if (pressure) begin
      fork
        begin
          hold_rx = 1'b1;
          repeat (HOLD_CYCLES) @(negedge clk);
          hold_rx = 1'b0;
        end
      join_none
    end
    counted = 0;
    while (counted < PHASE_WORDS) begin
      r = $urandom_range(99);
      if (r < 75) begin
        send_frame();
        counted += rc_dbus_pkg::FRAME_BYTES + 1;
      end else if (r < 90) begin
        // wrong length, including short, one off and past saturation
        n = $urandom_range(45);
        if (n == rc_dbus_pkg::FRAME_BYTES) n = rc_dbus_pkg::FRAME_BYTES + 1;
        for (i = 0; i < n; i++)
          send_word(rc_dbus_pkg::MODE_DATA, 8'($urandom_range(255)));
        send_word(rc_dbus_pkg::MODE_IDLE, 8'($urandom_range(255)));
        counted += n + 1;
      end else begin
        send_word(1'($urandom_range(1)), 8'($urandom_range(255)));
        counted += 1;
      end
    end
    wait_quiet();
  endtask

  initial begin
    int i;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: idle on an empty frame, a short frame, an all-ones frame
    send_word(rc_dbus_pkg::MODE_IDLE, 8'h00);
    for (i = 0; i < 3; i++) send_word(rc_dbus_pkg::MODE_DATA, 8'h00);
    send_word(rc_dbus_pkg::MODE_IDLE, 8'hff);
    for (i = 0; i < rc_dbus_pkg::FRAME_BYTES; i++)
      send_word(rc_dbus_pkg::MODE_DATA, 8'hff);
    send_word(rc_dbus_pkg::MODE_IDLE, 8'h00);
    wait_quiet();

    run_phase(11'd0,    0,  0,  1'b0);
    run_phase(11'd1024, 47, 0,  1'b0);
    run_phase(11'd1023, 0,  47, 1'b0);
    run_phase(rc_dbus_pkg::LIMIT_RESET, 25, 25, 1'b0);
    run_phase(11'($urandom_range(1024)), 0, 0, 1'b1);

    wait_quiet();
    if (model.faults == 0 && model.due_count() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
